// File: sv/mfb_pkg.sv
// Shared types and constants for the monochrome frame buffer fill/blit block.
// Holds opcodes, result kinds, the job record passed front to back and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package mfb_pkg;

    // Default geometry and job queue size
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Fixed field widths
    localparam int COORD_W   = 8;
    localparam int PAGE_W    = 5;
    localparam int PAGE_ROWS = 8;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_START = 2'd1,
        OP_DATA  = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FILL   = 2'd0,
        KIND_BLIT   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_REJECT = 2'd3
    } result_kind_t;

    // What the back end has to do with a queued job
    typedef enum logic [1:0] {
        JOB_NOTE = 2'd0,   // result only, no buffer access
        JOB_FILL = 2'd1,
        JOB_BLIT = 2'd2,
        JOB_READ = 2'd3
    } job_mode_t;

    // One unit of work: a clipped rectangle of columns x0..x1 and rows y0..y1
    typedef struct packed {
        job_mode_t          mode;
        result_kind_t       kind;
        logic               has_result;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        logic               color;
        logic [7:0]         bits;
    } job_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_RUN    = 3'd2,
        ST_DRAIN  = 3'd3,
        ST_RESULT = 3'd4
    } back_state_t;

endpackage

// File: sv/mfb_front.sv
// Front end: accepts items, keeps the open blit's cursor and turns each item
// into a clipped job for the back end. Depends on mfb_pkg.
`timescale 1ns / 1ps

module mfb_front #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            pos_x,
    input  logic [7:0]            pos_y,
    input  logic [7:0]            rect_width,
    input  logic [7:0]            rect_height,
    input  logic                  pixel_color,
    input  logic [7:0]            bitmap_byte,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mfb_pkg::job_t         push_job,
    input  mfb_pkg::back_status_t status
);

    localparam logic [9:0] X_LIMIT = 10'(SCREEN_WIDTH);
    localparam logic [9:0] Y_LIMIT = 10'(SCREEN_HEIGHT);
    localparam logic [7:0] X_MAX   = 8'(SCREEN_WIDTH - 1);
    localparam logic [7:0] Y_MAX   = 8'(SCREEN_HEIGHT - 1);

    logic       active_reg,    active_next;
    logic [7:0] origin_reg,    origin_next;
    logic [7:0] width_reg,     width_next;
    logic [7:0] rows_left_reg, rows_left_next;
    logic [8:0] cur_row_reg,   cur_row_next;
    logic [7:0] cur_col_reg,   cur_col_next;

    logic       accept;
    logic       need_push;

    logic [9:0] fill_x_end, fill_y_end;
    logic       fill_empty;

    logic [9:0] col_start, col_last;
    logic [7:0] col_remain;
    logic [2:0] span_m1;
    logic       data_off;
    logic [8:0] col_next;
    logic       row_end;
    logic [7:0] rows_dec;
    logic       blit_last;

    assign in_ready = push_ready && !status.clearing;
    assign accept   = in_valid && in_ready;
    assign push_valid = in_valid && !status.clearing && need_push;

    // Fill rectangle clipping
    assign fill_x_end = {2'b00, pos_x} + {2'b00, rect_width} - 10'd1;
    assign fill_y_end = {2'b00, pos_y} + {2'b00, rect_height} - 10'd1;
    assign fill_empty = (rect_width == 8'd0) || (rect_height == 8'd0) ||
                        ({2'b00, pos_x} >= X_LIMIT) || ({2'b00, pos_y} >= Y_LIMIT);

    // Span painted by the next data byte of the open blit
    assign col_start  = {2'b00, origin_reg} + {2'b00, cur_col_reg};
    assign col_remain = width_reg - cur_col_reg;
    assign span_m1    = (col_remain >= 8'd8) ? 3'd7 : 3'(col_remain - 8'd1);
    assign col_last   = col_start + {7'b0, span_m1};
    assign data_off   = (col_start >= X_LIMIT) || ({1'b0, cur_row_reg} >= Y_LIMIT);
    assign col_next   = {1'b0, cur_col_reg} + 9'd8;
    assign row_end    = col_next >= {1'b0, width_reg};
    assign rows_dec   = rows_left_reg - 8'd1;
    assign blit_last  = row_end && (rows_dec == 8'd0);

    // Classify the item, build its job and step the blit cursor
    always_comb
    begin
        active_next    = active_reg;
        origin_next    = origin_reg;
        width_next     = width_reg;
        rows_left_next = rows_left_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        need_push      = 1'b0;

        push_job            = '0;
        push_job.mode       = mfb_pkg::JOB_NOTE;
        push_job.kind       = mfb_pkg::KIND_REJECT;
        push_job.has_result = 1'b1;
        push_job.color      = pixel_color;
        push_job.bits       = bitmap_byte;

        case (mfb_pkg::opcode_t'(opcode))
            mfb_pkg::OP_FILL:
            begin
                need_push     = 1'b1;
                push_job.kind = mfb_pkg::KIND_FILL;
                push_job.mode = fill_empty ? mfb_pkg::JOB_NOTE : mfb_pkg::JOB_FILL;
                push_job.x0   = pos_x;
                push_job.y0   = pos_y;
                push_job.x1   = (fill_x_end >= X_LIMIT) ? X_MAX : fill_x_end[7:0];
                push_job.y1   = (fill_y_end >= Y_LIMIT) ? Y_MAX : fill_y_end[7:0];
            end
            mfb_pkg::OP_START:
            begin
                origin_next  = pos_x;
                width_next   = rect_width;
                cur_row_next = {1'b0, pos_y};
                cur_col_next = 8'd0;
                push_job.kind = mfb_pkg::KIND_BLIT;
                if ((rect_width == 8'd0) || (rect_height == 8'd0))
                begin
                    // empty bitmap: done at once, nothing opens
                    active_next    = 1'b0;
                    rows_left_next = 8'd0;
                    need_push      = 1'b1;
                end
                else
                begin
                    active_next    = 1'b1;
                    rows_left_next = rect_height;
                end
            end
            mfb_pkg::OP_DATA:
            begin
                if (!active_reg)
                begin
                    need_push = 1'b1;   // stray byte, rejected
                end
                else
                begin
                    push_job.kind       = mfb_pkg::KIND_BLIT;
                    push_job.has_result = blit_last;
                    push_job.mode       = data_off ? mfb_pkg::JOB_NOTE : mfb_pkg::JOB_BLIT;
                    push_job.x0         = col_start[7:0];
                    push_job.x1         = (col_last >= X_LIMIT) ? X_MAX : col_last[7:0];
                    push_job.y0         = cur_row_reg[7:0];
                    push_job.y1         = cur_row_reg[7:0];
                    need_push           = blit_last || !data_off;
                    if (row_end)
                    begin
                        cur_col_next   = 8'd0;
                        cur_row_next   = (cur_row_reg != 9'h1FF) ? cur_row_reg + 9'd1
                                                                 : cur_row_reg;
                        rows_left_next = rows_dec;
                        if (rows_dec == 8'd0)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cur_col_next = col_next[7:0];
                    end
                end
            end
            mfb_pkg::OP_READ:
            begin
                need_push = 1'b1;
                if (({2'b00, pos_x} < X_LIMIT) && ({2'b00, pos_y} < Y_LIMIT))
                begin
                    push_job.mode = mfb_pkg::JOB_READ;
                    push_job.kind = mfb_pkg::KIND_READ;
                    push_job.x0   = pos_x;
                    push_job.x1   = pos_x;
                    push_job.y0   = pos_y;
                    push_job.y1   = pos_y;
                end
            end
            default:
            begin
                need_push = 1'b0;
            end
        endcase
    end

    // Blit cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            origin_reg    <= 8'd0;
            width_reg     <= 8'd0;
            rows_left_reg <= 8'd0;
            cur_row_reg   <= 9'd0;
            cur_col_reg   <= 8'd0;
        end
        else if (accept)
        begin
            active_reg    <= active_next;
            origin_reg    <= origin_next;
            width_reg     <= width_next;
            rows_left_reg <= rows_left_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
        end
    end

endmodule

// File: sv/mfb_queue.sv
// Short job queue between the front and back ends.
// Depends on mfb_pkg for the job record.
`timescale 1ns / 1ps

module mfb_queue #(
    parameter int DEPTH = mfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mfb_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mfb_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mfb_pkg::job_t    entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/mfb_back.sv
// Back end: owns the frame buffer memory, clears it after reset and carries
// out jobs by pipelined read-modify-write, one byte per cycle. Depends on mfb_pkg.
`timescale 1ns / 1ps

module mfb_back #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  mfb_pkg::job_t         job,
    output mfb_pkg::back_status_t status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic [7:0]            read_byte
);

    localparam int STORE_SIZE = SCREEN_WIDTH *
                                ((SCREEN_HEIGHT + mfb_pkg::PAGE_ROWS - 1) / mfb_pkg::PAGE_ROWS);
    localparam int AW = $clog2(STORE_SIZE);
    localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_SIZE - 1);
    localparam int PW = mfb_pkg::PAGE_W;

    mfb_pkg::back_state_t state_reg, state_next;
    mfb_pkg::job_t        job_reg,   job_next;
    logic [7:0]           cur_x_reg, cur_x_next;
    logic [PW-1:0]        cur_page_reg, cur_page_next;
    logic [7:0]           shreg_reg, shreg_next;

    logic                 wb_valid_reg, wb_valid_next;
    logic [AW-1:0]        wb_addr_reg,  wb_addr_next;
    logic [7:0]           wb_mask_reg,  wb_mask_next;
    logic [7:0]           wb_val_reg,   wb_val_next;

    logic [AW-1:0]        clr_addr_reg, clr_addr_next;

    logic                 out_valid_reg, out_valid_next;
    mfb_pkg::result_kind_t out_kind_reg, out_kind_next;
    logic [7:0]           out_byte_reg,  out_byte_next;

    logic [7:0]           mem [STORE_SIZE];
    logic [7:0]           rdata_reg;

    logic [PW-1:0]        page0, page1;
    logic [2:0]           lo, hi;
    logic [7:0]           run_mask;
    logic                 pix;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 last_step;
    logic                 out_free;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic [7:0]           merged;

    // Byte address and bit mask of the current step
    assign page0     = job_reg.y0[7:3];
    assign page1     = job_reg.y1[7:3];
    assign lo        = (cur_page_reg == page0) ? job_reg.y0[2:0] : 3'd0;
    assign hi        = (cur_page_reg == page1) ? job_reg.y1[2:0] : 3'd7;
    assign run_mask  = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    assign pix       = (job_reg.mode == mfb_pkg::JOB_BLIT) ? shreg_reg[7] : job_reg.color;
    assign rd_addr   = AW'(cur_x_reg) + AW'(32'(cur_page_reg) * SCREEN_WIDTH);
    assign rd_en     = state_reg == mfb_pkg::ST_RUN;
    assign last_step = (cur_x_reg == job_reg.x1) && (cur_page_reg == page1);
    assign out_free  = !out_valid_reg || out_ready;

    // Write port: clearing pass or merge of the byte read in the previous cycle
    assign merged    = (rdata_reg & ~wb_mask_reg) | (wb_val_reg & wb_mask_reg);
    assign mem_we    = (state_reg == mfb_pkg::ST_CLEAR) || wb_valid_reg;
    assign mem_waddr = (state_reg == mfb_pkg::ST_CLEAR) ? clr_addr_reg : wb_addr_reg;
    assign mem_wdata = (state_reg == mfb_pkg::ST_CLEAR) ? 8'd0 : merged;

    assign job_ready       = state_reg == mfb_pkg::ST_IDLE;
    assign status.clearing = state_reg == mfb_pkg::ST_CLEAR;
    assign out_valid       = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign read_byte       = out_byte_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cur_x_next     = cur_x_reg;
        cur_page_next  = cur_page_reg;
        shreg_next     = shreg_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        wb_mask_next   = wb_mask_reg;
        wb_val_next    = wb_val_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;

        case (state_reg)
            mfb_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next      = job;
                    cur_x_next    = job.x0;
                    cur_page_next = job.y0[7:3];
                    shreg_next    = job.bits;
                    if (job.mode != mfb_pkg::JOB_NOTE)
                    begin
                        state_next = mfb_pkg::ST_RUN;
                    end
                    else if (job.has_result)
                    begin
                        state_next = mfb_pkg::ST_RESULT;
                    end
                end
            end
            mfb_pkg::ST_RUN:
            begin
                wb_valid_next = job_reg.mode != mfb_pkg::JOB_READ;
                wb_addr_next  = rd_addr;
                wb_mask_next  = run_mask;
                wb_val_next   = {8{pix}};
                if (last_step)
                begin
                    state_next = mfb_pkg::ST_DRAIN;
                end
                else if (cur_x_reg == job_reg.x1)
                begin
                    // next page, back to the first column
                    cur_x_next    = job_reg.x0;
                    cur_page_next = cur_page_reg + PW'(1);
                end
                else
                begin
                    cur_x_next = cur_x_reg + 8'd1;
                    shreg_next = {shreg_reg[6:0], 1'b0};
                end
            end
            mfb_pkg::ST_DRAIN:
            begin
                state_next = job_reg.has_result ? mfb_pkg::ST_RESULT : mfb_pkg::ST_IDLE;
            end
            mfb_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = job_reg.kind;
                    out_byte_next  = (job_reg.mode == mfb_pkg::JOB_READ) ? rdata_reg : 8'd0;
                    state_next     = mfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        cur_x_reg    <= cur_x_next;
        cur_page_reg <= cur_page_next;
        shreg_reg    <= shreg_next;
        wb_addr_reg  <= wb_addr_next;
        wb_mask_reg  <= wb_mask_next;
        wb_val_reg   <= wb_val_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
    end

    // Frame buffer memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // A read never targets the byte whose merged value is being written
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_valid_reg && rd_en) |-> (wb_addr_reg != rd_addr))
        else $error("read and pending write hit the same byte");

    // Jobs are taken only when the sequencer is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |-> (state_reg == mfb_pkg::ST_IDLE))
        else $error("job taken outside idle");

    // Only read results carry data
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != mfb_pkg::KIND_READ)) |-> (out_byte_reg == 8'd0))
        else $error("non-read result with data");

    // No merge write or result is pending while the buffer is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfb_pkg::ST_CLEAR) |-> (!wb_valid_reg && !out_valid_reg))
        else $error("activity during clearing pass");

endmodule

// File: sv/mono_framebuffer_fill_blit.sv
// Monochrome page-layout frame buffer with rectangle fill, bitmap blit and byte
// read. After reset the buffer is cleared one byte per cycle, all SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8) bytes (1024 at the default size), and no item is taken
// until that pass ends. Items are classified at the input and queued; the back end
// updates the buffer by read-modify-write through a single-port-per-direction
// memory, one byte per cycle. A fill rewrites each byte it touches (clipped
// columns times pages), then gives its result; an empty or fully off-screen fill
// gives its result only. A bitmap data byte rewrites one byte per clipped pixel
// (up to eight), with a result only when it completes the bitmap; a byte wholly off
// screen ends at the input unless it completes the bitmap. A read fetches one byte
// and returns it; a rejected item gives its result only. A blit start ends at the
// input unless the bitmap is empty. The job queue lets several items be taken
// while the back end is busy; a finished result waits in an output register, and
// the back end stalls only when the next result is ready before that one is taken.
`timescale 1ns / 1ps

module mono_framebuffer_fill_blit #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int QUEUE_DEPTH   = mfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] rect_width,
    input  logic [7:0] rect_height,
    input  logic       pixel_color,
    input  logic [7:0] bitmap_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] read_byte
);

    logic                  push_valid, push_ready;
    mfb_pkg::job_t         push_job;
    logic                  pop_valid, pop_ready;
    mfb_pkg::job_t         pop_job;
    mfb_pkg::back_status_t status;

    // Item intake and blit cursor
    mfb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .pixel_color (pixel_color),
        .bitmap_byte (bitmap_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job),
        .status      (status)
    );

    // Job queue
    mfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Buffer engine and result register
    mfb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_job),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .read_byte   (read_byte)
    );

endmodule
